[rtl/mscc_pkg.sv]
// Package for the Mode S CRC-24 check and single-bit correction block.
// Holds widths, status codes, the frame struct, CRC byte update and syndrome table.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package mscc_pkg;

  localparam int FRAME_BYTES = 14;
  localparam int MSG_BITS    = FRAME_BYTES * 8;
  localparam int POS_W       = 4;
  localparam int CRC_W       = 24;
  localparam int CNT_W       = 16;
  localparam int DF_W        = 5;

  localparam logic [CRC_W-1:0] CRC_POLY = 24'hFFF409;
  localparam logic [DF_W-1:0]  DF_EXT   = 5'd17;

  typedef enum logic [1:0] {
    ST_VALID     = 2'd0,
    ST_CORRECTED = 2'd1,
    ST_INVALID   = 2'd2
  } chk_status_t;

  typedef struct packed {
    logic [CRC_W-1:0] crc;
    logic [7:0]       b0;
    logic [7:0]       b4;
  } frame_t;

  typedef logic [MSG_BITS-1:0][CRC_W-1:0] syn_table_t;

  // one byte through the CRC, MSB first
  function automatic logic [CRC_W-1:0] crc_feed(input logic [CRC_W-1:0] crc_in,
                                                 input logic [7:0] b);
    logic [CRC_W-1:0] c;
    c = crc_in ^ {b, 16'h0000};
    for (int k = 0; k < 8; k++) begin
      if (c[CRC_W-1]) begin
        c = {c[CRC_W-2:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[CRC_W-2:0], 1'b0};
      end
    end
    return c;
  endfunction

  // syndrome of each single-bit error, bit 0 = MSB of byte 0
  function automatic syn_table_t syndrome_table();
    syn_table_t       t;
    logic [CRC_W-1:0] c;
    logic [7:0]       b;
    for (int bi = 0; bi < MSG_BITS; bi++) begin
      c = '0;
      for (int i = 0; i < FRAME_BYTES; i++) begin
        b = (i == (bi >> 3)) ? (8'h80 >> (bi & 7)) : 8'h00;
        c = crc_feed(c, b);
      end
      t[bi] = c;
    end
    return t;
  endfunction

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
    return (c == {CNT_W{1'b1}}) ? c : c + 1'b1;
  endfunction

endpackage

`default_nettype wire

[rtl/mscc_if.sv]
// Valid/ready channel interfaces for message bytes and check results.
// Depends on mscc_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface mscc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       msg_start;

  modport source (output valid, output data_byte, output msg_start, input ready);
  modport sink   (input valid, input data_byte, input msg_start, output ready);
endinterface

interface mscc_out_if;
  logic                         valid;
  logic                         ready;
  logic [1:0]                   chk_status;
  logic [mscc_pkg::DF_W-1:0]    downlink_format;
  logic [mscc_pkg::DF_W-1:0]    type_code;
  logic [mscc_pkg::CNT_W-1:0]   message_count;
  logic [mscc_pkg::CNT_W-1:0]   valid_count;
  logic [mscc_pkg::CNT_W-1:0]   corrected_count;
  logic [mscc_pkg::CNT_W-1:0]   invalid_count;
  logic [mscc_pkg::CNT_W-1:0]   df17_count;

  modport source (output valid, output chk_status, output downlink_format,
                  output type_code, output message_count, output valid_count,
                  output corrected_count, output invalid_count, output df17_count,
                  input ready);
  modport sink   (input valid, input chk_status, input downlink_format,
                  input type_code, input message_count, input valid_count,
                  input corrected_count, input invalid_count, input df17_count,
                  output ready);
endinterface

`default_nettype wire

[rtl/mscc_crc_acc.sv]
// Byte accumulator: runs the CRC-24 over each message, keeps bytes 0 and 4,
// and hands a finished frame to the syndrome stage. Depends on mscc_pkg, mscc_if.
`timescale 1ns / 1ps
`default_nettype none

module mscc_crc_acc (
  input  wire logic             clk,
  input  wire logic             rst,
  mscc_in_if.sink               msg,
  output mscc_pkg::frame_t      frm,
  output logic                  frm_valid,
  input  wire logic             frm_ready
);

  logic [mscc_pkg::POS_W-1:0] pos;
  logic [mscc_pkg::CRC_W-1:0] crc;
  logic [7:0]                 b0;
  logic [7:0]                 b4;

  logic                       accept;
  logic                       new_msg;
  logic                       last;
  logic [mscc_pkg::POS_W-1:0] pos_cur;
  logic [mscc_pkg::CRC_W-1:0] crc_next;
  logic [7:0]                 b0_next;
  logic [7:0]                 b4_next;

  assign msg.ready = !frm_valid || frm_ready;
  assign accept    = msg.valid && msg.ready;
  assign new_msg   = msg.msg_start || (pos == '0);
  assign pos_cur   = new_msg ? '0 : pos;
  assign last      = (pos_cur == mscc_pkg::POS_W'(mscc_pkg::FRAME_BYTES - 1));
  assign crc_next  = mscc_pkg::crc_feed(new_msg ? '0 : crc, msg.data_byte);
  assign b0_next   = (pos_cur == mscc_pkg::POS_W'(0)) ? msg.data_byte : b0;
  assign b4_next   = (pos_cur == mscc_pkg::POS_W'(4)) ? msg.data_byte : b4;

  always_ff @(posedge clk) begin
    if (rst) begin
      pos       <= '0;
      crc       <= '0;
      b0        <= '0;
      b4        <= '0;
      frm_valid <= 1'b0;
    end else begin
      if (accept) begin
        pos <= last ? '0 : pos_cur + 1'b1;
        crc <= last ? '0 : crc_next;
        b0  <= b0_next;
        b4  <= b4_next;
      end
      if (accept && last) begin
        frm_valid <= 1'b1;
      end else if (frm_ready) begin
        frm_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && last) begin
      frm.crc <= crc_next;
      frm.b0  <= b0_next;
      frm.b4  <= b4_next;
    end
  end

  a_last_restarts: assert property (@(posedge clk) disable iff (rst)
    accept && last |=> pos == '0 && frm_valid)
    else $error("frame not handed off or position not cleared");

  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    pos < mscc_pkg::POS_W'(mscc_pkg::FRAME_BYTES))
    else $error("byte position out of range");

  a_frame_holds: assert property (@(posedge clk) disable iff (rst)
    frm_valid && !frm_ready |=> frm_valid && $stable(frm))
    else $error("waiting frame changed");

endmodule

`default_nettype wire

[rtl/mscc_syn_fix.sv]
// Syndrome stage: compares the final CRC with all single-bit syndromes,
// corrects bytes 0 and 4, extracts DF / type code, keeps saturating counts.
// Depends on mscc_pkg, mscc_if.
`timescale 1ns / 1ps
`default_nettype none

module mscc_syn_fix (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire mscc_pkg::frame_t   frm,
  input  wire logic               frm_valid,
  output logic                    frm_ready,
  mscc_out_if.source              result
);

  localparam mscc_pkg::syn_table_t SYN = mscc_pkg::syndrome_table();

  logic [mscc_pkg::MSG_BITS-1:0] match;
  logic                          zero_syn;
  logic                          hit;
  logic [7:0]                    fix0;
  logic [7:0]                    fix4;
  logic [7:0]                    b0c;
  logic [7:0]                    b4c;
  logic [mscc_pkg::DF_W-1:0]     df;
  logic [mscc_pkg::DF_W-1:0]     tc;
  logic                          is_ext;
  mscc_pkg::chk_status_t         status_next;
  logic                          load;

  logic                          out_valid;
  mscc_pkg::chk_status_t         status;
  logic [mscc_pkg::DF_W-1:0]     df_q;
  logic [mscc_pkg::DF_W-1:0]     tc_q;
  logic [mscc_pkg::CNT_W-1:0]    msg_cnt;
  logic [mscc_pkg::CNT_W-1:0]    val_cnt;
  logic [mscc_pkg::CNT_W-1:0]    cor_cnt;
  logic [mscc_pkg::CNT_W-1:0]    inv_cnt;
  logic [mscc_pkg::CNT_W-1:0]    ext_cnt;

  // single-bit syndromes are distinct and nonzero, so at most one match
  always_comb begin
    for (int i = 0; i < mscc_pkg::MSG_BITS; i++) begin
      match[i] = (frm.crc == SYN[i]);
    end
    for (int k = 0; k < 8; k++) begin
      fix0[7-k] = match[k];
      fix4[7-k] = match[32+k];
    end
  end

  assign zero_syn = (frm.crc == '0);
  assign hit      = |match;
  assign b0c      = frm.b0 ^ fix0;
  assign b4c      = frm.b4 ^ fix4;
  assign df       = b0c[7:3];
  assign is_ext   = (df == mscc_pkg::DF_EXT);
  assign tc       = is_ext ? b4c[7:3] : '0;

  always_comb begin
    priority if (zero_syn) begin
      status_next = mscc_pkg::ST_VALID;
    end else if (hit) begin
      status_next = mscc_pkg::ST_CORRECTED;
    end else begin
      status_next = mscc_pkg::ST_INVALID;
    end
  end

  assign frm_ready = !out_valid || result.ready;
  assign load      = frm_valid && frm_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      msg_cnt   <= '0;
      val_cnt   <= '0;
      cor_cnt   <= '0;
      inv_cnt   <= '0;
      ext_cnt   <= '0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
      if (load) begin
        msg_cnt <= mscc_pkg::sat_inc(msg_cnt);
        unique case (status_next)
          mscc_pkg::ST_VALID:     val_cnt <= mscc_pkg::sat_inc(val_cnt);
          mscc_pkg::ST_CORRECTED: cor_cnt <= mscc_pkg::sat_inc(cor_cnt);
          default:                inv_cnt <= mscc_pkg::sat_inc(inv_cnt);
        endcase
        if (is_ext) begin
          ext_cnt <= mscc_pkg::sat_inc(ext_cnt);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      status <= status_next;
      df_q   <= df;
      tc_q   <= tc;
    end
  end

  assign result.valid           = out_valid;
  assign result.chk_status      = status;
  assign result.downlink_format = df_q;
  assign result.type_code       = tc_q;
  assign result.message_count   = msg_cnt;
  assign result.valid_count     = val_cnt;
  assign result.corrected_count = cor_cnt;
  assign result.invalid_count   = inv_cnt;
  assign result.df17_count      = ext_cnt;

  a_total_steps: assert property (@(posedge clk) disable iff (rst)
    load |=> msg_cnt == $past(msg_cnt) + 1'b1 || $past(msg_cnt) == {mscc_pkg::CNT_W{1'b1}})
    else $error("message count did not advance");

  a_one_class: assert property (@(posedge clk) disable iff (rst)
    load |=> $countones({val_cnt != $past(val_cnt), cor_cnt != $past(cor_cnt),
                         inv_cnt != $past(inv_cnt)}) <= 1)
    else $error("more than one status count moved");

  a_tc_only_ext: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.type_code != '0 |-> result.downlink_format == mscc_pkg::DF_EXT)
    else $error("type code set for non-extended format");

  a_idle_counts: assert property (@(posedge clk) disable iff (rst)
    !load |=> $stable(msg_cnt) && $stable(ext_cnt))
    else $error("count moved without a frame");

endmodule

`default_nettype wire

[rtl/mode_s_crc_check_correct.sv]
// Top level of the Mode S CRC-24 check with single-bit correction.
// Depends on mscc_pkg, mscc_if, mscc_crc_acc, mscc_syn_fix.
//
//   channel  dir  payload                                         per item
//   msg      in   data_byte[7:0], msg_start                       one message byte
//   result   out  chk_status, downlink_format, type_code, counts  one checked message
//
// One byte is taken every cycle unless a frame waits behind a stalled result; the
// CRC byte update is combinational. A finished frame is registered in the accumulator,
// and the syndrome compare and correction stage then registers its result.
// rst is synchronous and clears position, CRC, kept bytes, counts and valid flags.
// A stalled result holds in its register while the next frame waits one stage back.
`timescale 1ns / 1ps
`default_nettype none

module mode_s_crc_check_correct (
  input  wire logic   clk,
  input  wire logic   rst,
  mscc_in_if.sink     msg,
  mscc_out_if.source  result
);

  mscc_pkg::frame_t frm;
  logic             frm_valid;
  logic             frm_ready;

  mscc_crc_acc u_acc (
    .clk       (clk),
    .rst       (rst),
    .msg       (msg),
    .frm       (frm),
    .frm_valid (frm_valid),
    .frm_ready (frm_ready)
  );

  mscc_syn_fix u_fix (
    .clk       (clk),
    .rst       (rst),
    .frm       (frm),
    .frm_valid (frm_valid),
    .frm_ready (frm_ready),
    .result    (result)
  );

endmodule

`default_nettype wire

[sim/mode_s_crc_check_correct_test.sv]
// Testbench for mode_s_crc_check_correct: Mode S messages go in byte by byte, and the
// check results are compared with a local CRC-24 predictor, one per complete message.
// Depends on mscc_pkg, mscc_if and the RTL of the block.
`timescale 1ns / 1ps

module mode_s_crc_check_correct_test;

  localparam logic [24:0] CRC_GEN     = 25'h1FFF409;
  localparam int          WATCHDOG    = 3000;
  localparam int          LONG_STALL  = 400;
  localparam int          PHASE_BYTES = 290;
  localparam int          MAX_REPORTS = 10;

  typedef struct packed {
    logic [7:0] data;
    logic       start;
  } msg_byte_t;

  typedef struct packed {
    mscc_pkg::chk_status_t      status;
    logic [mscc_pkg::DF_W-1:0]  df;
    logic [mscc_pkg::DF_W-1:0]  tc;
    logic [mscc_pkg::CNT_W-1:0] total;
    logic [mscc_pkg::CNT_W-1:0] clean;
    logic [mscc_pkg::CNT_W-1:0] fixed;
    logic [mscc_pkg::CNT_W-1:0] bad;
    logic [mscc_pkg::CNT_W-1:0] ext;
  } check_rec_t;

  logic clk = 1'b0;
  logic rst;

  mscc_in_if  msg_ch ();
  mscc_out_if res_ch ();

  mode_s_crc_check_correct dut (
    .clk    (clk),
    .rst    (rst),
    .msg    (msg_ch),
    .result (res_ch)
  );

  always #2 clk = ~clk;

  msg_byte_t   byte_q[$];
  check_rec_t  check_q[$];
  logic [23:0] bit_syndrome [mscc_pkg::MSG_BITS];
  logic [7:0]  frame_buf [mscc_pkg::FRAME_BYTES];

  // predictor state
  int                         pos;
  logic [23:0]                crc_acc;
  logic [7:0]                 kept_b0, kept_b4;
  logic [mscc_pkg::CNT_W-1:0] n_total, n_clean, n_fixed, n_bad, n_ext;

  int send_idle_pct, stall_pct;
  int stall_requests, stall_served, stall_left;
  int bytes_in, bytes_queued, results_seen, failures, idle_cycles;

  function automatic logic [23:0] crc24_byte(input logic [23:0] c, input logic [7:0] b);
    logic fb;
    for (int k = 7; k >= 0; k--) begin
      fb = c[23] ^ b[k];
      c  = {c[22:0], 1'b0} ^ (fb ? CRC_GEN[23:0] : 24'h0);
    end
    return c;
  endfunction

  function automatic logic [mscc_pkg::CNT_W-1:0] bump(input logic [mscc_pkg::CNT_W-1:0] c);
    return (c == {mscc_pkg::CNT_W{1'b1}}) ? c : c + 1'b1;
  endfunction

  function automatic string fmt_rec(input check_rec_t r);
    return $sformatf("status %0d df %0d tc %0d counts %0d/%0d/%0d/%0d/%0d",
                     r.status, r.df, r.tc, r.total, r.clean, r.fixed, r.bad, r.ext);
  endfunction

  function automatic void report(input string what);
    failures++;
    if (failures <= MAX_REPORTS) $display("ERROR at %0t: %s", $realtime, what);
  endfunction

  function automatic void predict_byte(input logic [7:0] b, input logic start);
    check_rec_t r;
    logic [7:0] c0, c4;
    logic       hit;
    if (start || pos == 0) begin
      pos     = 0;
      crc_acc = '0;
    end
    if (pos == 0) kept_b0 = b;
    if (pos == 4) kept_b4 = b;
    crc_acc = crc24_byte(crc_acc, b);
    pos++;
    if (pos < mscc_pkg::FRAME_BYTES) return;

    c0  = kept_b0;
    c4  = kept_b4;
    hit = 1'b0;
    if (crc_acc == '0) begin
      r.status = mscc_pkg::ST_VALID;
    end else begin
      r.status = mscc_pkg::ST_INVALID;
      for (int i = 0; i < mscc_pkg::MSG_BITS; i++) begin
        if (!hit && bit_syndrome[i] == crc_acc) begin
          hit = 1'b1;
          r.status = mscc_pkg::ST_CORRECTED;
          if (i / 8 == 0) c0 ^= 8'h80 >> (i % 8);
          if (i / 8 == 4) c4 ^= 8'h80 >> (i % 8);
        end
      end
    end
    r.df = c0[7:3];
    r.tc = (r.df == mscc_pkg::DF_EXT) ? c4[7:3] : '0;

    n_total = bump(n_total);
    case (r.status)
      mscc_pkg::ST_VALID:     n_clean = bump(n_clean);
      mscc_pkg::ST_CORRECTED: n_fixed = bump(n_fixed);
      default:                n_bad   = bump(n_bad);
    endcase
    if (r.df == mscc_pkg::DF_EXT) n_ext = bump(n_ext);
    r.total = n_total;
    r.clean = n_clean;
    r.fixed = n_fixed;
    r.bad   = n_bad;
    r.ext   = n_ext;

    pos     = 0;
    crc_acc = '0;
    check_q.push_back(r);
  endfunction

  // sender
  always @(posedge clk) begin : drive_p
    msg_byte_t nxt;
    if (rst) begin
      msg_ch.valid <= 1'b0;
    end else begin
      if (msg_ch.valid && msg_ch.ready) begin
        predict_byte(msg_ch.data_byte, msg_ch.msg_start);
        bytes_in++;
      end
      if (!msg_ch.valid || msg_ch.ready) begin
        if (byte_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          nxt = byte_q.pop_front();
          msg_ch.valid     <= 1'b1;
          msg_ch.data_byte <= nxt.data;
          msg_ch.msg_start <= nxt.start;
        end else begin
          msg_ch.valid <= 1'b0;
        end
      end
    end
  end

  // receiver, with an occasional long hold-off on request
  always @(posedge clk) begin
    if (rst) begin
      res_ch.ready <= 1'b0;
      stall_left   <= 0;
      stall_served <= 0;
    end else if (stall_left > 0) begin
      stall_left   <= stall_left - 1;
      res_ch.ready <= 1'b0;
    end else if (stall_served != stall_requests) begin
      stall_served <= stall_served + 1;
      stall_left   <= LONG_STALL;
      res_ch.ready <= 1'b0;
    end else begin
      res_ch.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin : check_p
    check_rec_t want, got;
    if (!rst && res_ch.valid && res_ch.ready) begin
      results_seen++;
      got.status = mscc_pkg::chk_status_t'(res_ch.chk_status);
      got.df     = res_ch.downlink_format;
      got.tc     = res_ch.type_code;
      got.total  = res_ch.message_count;
      got.clean  = res_ch.valid_count;
      got.fixed  = res_ch.corrected_count;
      got.bad    = res_ch.invalid_count;
      got.ext    = res_ch.df17_count;
      if (check_q.size() == 0) begin
        report({"result with nothing expected: ", fmt_rec(got)});
      end else begin
        want = check_q.pop_front();
        if (got !== want)
          report({"expected ", fmt_rec(want), " got ", fmt_rec(got)});
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (msg_ch.valid && msg_ch.ready) || (res_ch.valid && res_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG) begin
      $display("Timeout: no item moved for %0d cycles", WATCHDOG);
      $display("Some tests failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // random body bytes 0..10 with the given format; seal_frame adds parity
  task automatic fill_frame(input int df);
    for (int i = 0; i < mscc_pkg::FRAME_BYTES - 3; i++) frame_buf[i] = 8'($urandom_range(255));
    frame_buf[0][7:3] = mscc_pkg::DF_W'(df);
  endtask

  task automatic seal_frame();
    logic [23:0] c;
    c = '0;
    for (int i = 0; i < mscc_pkg::FRAME_BYTES - 3; i++) c = crc24_byte(c, frame_buf[i]);
    frame_buf[mscc_pkg::FRAME_BYTES-3] = c[23:16];
    frame_buf[mscc_pkg::FRAME_BYTES-2] = c[15:8];
    frame_buf[mscc_pkg::FRAME_BYTES-1] = c[7:0];
  endtask

  task automatic flip_bit(input int n);
    frame_buf[n / 8] ^= 8'h80 >> (n % 8);
  endtask

  task automatic queue_frame(input int nbytes, input logic start);
    msg_byte_t it;
    for (int i = 0; i < nbytes; i++) begin
      it.data  = frame_buf[i];
      it.start = (i == 0) ? start : 1'b0;
      byte_q.push_back(it);
    end
    bytes_queued += nbytes;
  endtask

  task automatic wait_drained();
    do @(negedge clk); while (byte_q.size() != 0 || msg_ch.valid || check_q.size() != 0);
  endtask

  task automatic random_message();
    int        r, b1, b2;
    msg_byte_t it;
    r = $urandom_range(99);
    fill_frame($urandom_range(1) ? int'(mscc_pkg::DF_EXT) : $urandom_range(31));
    seal_frame();
    if (r < 35) begin
      queue_frame(mscc_pkg::FRAME_BYTES, 1'b1);
    end else if (r < 65) begin
      flip_bit($urandom_range(mscc_pkg::MSG_BITS - 1));
      queue_frame(mscc_pkg::FRAME_BYTES, 1'b1);
    end else if (r < 75) begin
      b1 = $urandom_range(mscc_pkg::MSG_BITS - 1);
      b2 = (b1 + $urandom_range(1, mscc_pkg::MSG_BITS - 1)) % mscc_pkg::MSG_BITS;
      flip_bit(b1);
      flip_bit(b2);
      queue_frame(mscc_pkg::FRAME_BYTES, 1'b1);
    end else if (r < 82) begin
      for (int i = 0; i < mscc_pkg::FRAME_BYTES; i++) frame_buf[i] = 8'($urandom_range(255));
      queue_frame(mscc_pkg::FRAME_BYTES, 1'b1);
    end else if (r < 90) begin
      queue_frame($urandom_range(1, mscc_pkg::FRAME_BYTES - 1), 1'b1);
    end else if (r < 95) begin
      if ($urandom_range(1)) flip_bit($urandom_range(mscc_pkg::MSG_BITS - 1));
      queue_frame(mscc_pkg::FRAME_BYTES, 1'b0);
    end else begin
      repeat ($urandom_range(1, 5)) begin
        it.data  = 8'($urandom_range(255));
        it.start = 1'($urandom_range(1));
        byte_q.push_back(it);
        bytes_queued++;
      end
    end
  endtask

  initial begin
    int phase_start;
    msg_ch.valid     = 1'b0;
    msg_ch.data_byte = '0;
    msg_ch.msg_start = 1'b0;
    res_ch.ready     = 1'b0;
    rst              = 1'b1;
    send_idle_pct    = 0;
    stall_pct        = 0;
    stall_requests   = 0;
    bytes_in         = 0;
    bytes_queued     = 0;
    results_seen     = 0;
    failures         = 0;
    idle_cycles      = 0;
    pos              = 0;
    crc_acc          = '0;
    kept_b0          = '0;
    kept_b4          = '0;
    n_total          = '0;
    n_clean          = '0;
    n_fixed          = '0;
    n_bad            = '0;
    n_ext            = '0;

    for (int n = 0; n < mscc_pkg::MSG_BITS; n++) begin
      bit_syndrome[n] = '0;
      for (int i = 0; i < mscc_pkg::FRAME_BYTES; i++)
        bit_syndrome[n] = crc24_byte(bit_syndrome[n],
                                     (i == n / 8) ? 8'h80 >> (n % 8) : 8'h00);
    end

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // directed: all zeros, all ones, format and type code extremes
    for (int i = 0; i < mscc_pkg::FRAME_BYTES; i++) frame_buf[i] = 8'h00;
    queue_frame(mscc_pkg::FRAME_BYTES, 1'b1);
    for (int i = 0; i < mscc_pkg::FRAME_BYTES; i++) frame_buf[i] = 8'hFF;
    queue_frame(mscc_pkg::FRAME_BYTES, 1'b1);
    for (int i = 0; i < mscc_pkg::FRAME_BYTES - 3; i++) frame_buf[i] = 8'hFF;
    seal_frame();
    queue_frame(mscc_pkg::FRAME_BYTES, 1'b1);
    fill_frame(mscc_pkg::DF_EXT);
    frame_buf[4][7:3] = 5'd0;
    seal_frame();
    queue_frame(mscc_pkg::FRAME_BYTES, 1'b1);
    frame_buf[4][7:3] = 5'd31;
    seal_frame();
    queue_frame(mscc_pkg::FRAME_BYTES, 1'b1);
    // one flip turns format 17 into 16 on the wire; corrected back
    flip_bit(4);
    queue_frame(mscc_pkg::FRAME_BYTES, 1'b1);
    // format 16 sent with a flip so that it reads as 17 before correction
    fill_frame(16);
    seal_frame();
    flip_bit(4);
    queue_frame(mscc_pkg::FRAME_BYTES, 1'b1);
    // flip in the type code byte, and one in the last parity bit
    fill_frame(mscc_pkg::DF_EXT);
    seal_frame();
    flip_bit(32);
    queue_frame(mscc_pkg::FRAME_BYTES, 1'b1);
    flip_bit(32);
    flip_bit(mscc_pkg::MSG_BITS - 1);
    queue_frame(mscc_pkg::FRAME_BYTES, 1'b1);
    // two flips: uncorrectable, format 17 still counted if it reads so
    fill_frame(mscc_pkg::DF_EXT);
    seal_frame();
    flip_bit(40);
    flip_bit(90);
    queue_frame(mscc_pkg::FRAME_BYTES, 1'b1);
    // start arriving mid-message drops the partial one
    fill_frame(mscc_pkg::DF_EXT);
    seal_frame();
    queue_frame(6, 1'b1);
    queue_frame(mscc_pkg::FRAME_BYTES, 1'b1);
    // first byte without the start flag
    queue_frame(mscc_pkg::FRAME_BYTES, 1'b0);
    wait_drained();

    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 76; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 76; end
        default: begin send_idle_pct = 18; stall_pct = 18; end
      endcase
      phase_start = bytes_queued;
      while (bytes_queued - phase_start < PHASE_BYTES) begin
        random_message();
        if (byte_q.size() > 64) @(negedge clk);
      end
      wait_drained();
    end

    // receiver holds off while the sender keeps offering messages
    send_idle_pct = 0;
    stall_pct     = 0;
    stall_requests++;
    repeat (20) begin
      fill_frame($urandom_range(31));
      seal_frame();
      if ($urandom_range(1)) flip_bit($urandom_range(mscc_pkg::MSG_BITS - 1));
      queue_frame(mscc_pkg::FRAME_BYTES, 1'b1);
    end
    wait_drained();

    repeat (10) @(posedge clk);
    if (check_q.size() != 0)
      report($sformatf("%0d expected results never arrived", check_q.size()));

    $display("Sent %0d bytes, checked %0d results: %0d clean, %0d corrected, %0d bad",
             bytes_in, results_seen, n_clean, n_fixed, n_bad);
    $display("Format 17 messages: %0d; errors: %0d", n_ext, failures);
    if (failures == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

[mode_s_crc_check_correct.f]
rtl/mscc_pkg.sv
rtl/mscc_if.sv
rtl/mscc_crc_acc.sv
rtl/mscc_syn_fix.sv
rtl/mode_s_crc_check_correct.sv
sim/mode_s_crc_check_correct_test.sv
